// ----- design/salcp_pkg.sv -----
`timescale 1ns / 1ps

package salcp_pkg;

    // Default sizing
    localparam int MAX_LEN_DEF  = 1024;
    localparam int ALPHABET_DEF = 256;

    // Clamp for the distinct substring count
    localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_READ = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_code;
        logic        last;
        logic [10:0] rank_index;
    } item_t;

    typedef struct packed {
        logic [10:0] suffix_start;
        logic [9:0]  lcp_next;
        logic [19:0] distinct_count;
        logic        is_count;
        logic [1:0]  status;
    } result_t;

    localparam int NSTEP = 46;

    // Sequencer steps, one-hot
    typedef enum logic [NSTEP-1:0] {
        ST_IDLE     = 46'b1 << 0,
        ST_BLD_INIT = 46'b1 << 1,
        ST_CLR_B    = 46'b1 << 2,
        ST_SB_HA    = 46'b1 << 3,
        ST_SB_HB    = 46'b1 << 4,
        ST_SB_HC    = 46'b1 << 5,
        ST_PRA_B    = 46'b1 << 6,
        ST_PRB_B    = 46'b1 << 7,
        ST_SB_LA    = 46'b1 << 8,
        ST_SB_LB    = 46'b1 << 9,
        ST_SB_LC    = 46'b1 << 10,
        ST_SB_CA    = 46'b1 << 11,
        ST_SB_CB    = 46'b1 << 12,
        ST_SB_CC    = 46'b1 << 13,
        ST_SH_A     = 46'b1 << 14,
        ST_SH_B     = 46'b1 << 15,
        ST_CLR_D    = 46'b1 << 16,
        ST_DH_A     = 46'b1 << 17,
        ST_DH_B     = 46'b1 << 18,
        ST_DH_C     = 46'b1 << 19,
        ST_DH_D     = 46'b1 << 20,
        ST_PRA_D    = 46'b1 << 21,
        ST_PRB_D    = 46'b1 << 22,
        ST_DP_A     = 46'b1 << 23,
        ST_DP_B     = 46'b1 << 24,
        ST_DP_C     = 46'b1 << 25,
        ST_DP_D     = 46'b1 << 26,
        ST_RC_A     = 46'b1 << 27,
        ST_RC_B     = 46'b1 << 28,
        ST_RC_C     = 46'b1 << 29,
        ST_RC_D     = 46'b1 << 30,
        ST_CP_A     = 46'b1 << 31,
        ST_CP_B     = 46'b1 << 32,
        ST_RK_A     = 46'b1 << 33,
        ST_RK_B     = 46'b1 << 34,
        ST_KZ       = 46'b1 << 35,
        ST_KA       = 46'b1 << 36,
        ST_KB       = 46'b1 << 37,
        ST_KC       = 46'b1 << 38,
        ST_KD       = 46'b1 << 39,
        ST_KE       = 46'b1 << 40,
        ST_KF       = 46'b1 << 41,
        ST_KW       = 46'b1 << 42,
        ST_CNT_M    = 46'b1 << 43,
        ST_CNT_S    = 46'b1 << 44,
        ST_RD       = 46'b1 << 45
    } step_t;

    typedef struct packed {
        step_t step;
        logic  accept;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic last;
        logic read_ok;
        logic idx_end;
        logic r_last;
        logic k_ok;
        logic chr_eq;
        logic h_lt;
        logic h2_lt;
    } stat_t;

endpackage

// ----- design/salcp_ram.sv -----
`timescale 1ns / 1ps

module salcp_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/salcp_ctrl.sv -----
`timescale 1ns / 1ps

module salcp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  salcp_pkg::stat_t st,
    output salcp_pkg::cmd_t  cmd,
    output logic            busy
);

    import salcp_pkg::*;

    step_t state_reg, state_next;

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.step   = state_reg;
    assign cmd.accept = start && (state_reg == ST_IDLE);

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence the build passes and reads
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    if (!st.is_read)
                    begin
                        state_next = st.last ? ST_BLD_INIT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = st.read_ok ? ST_RD : ST_IDLE;
                    end
                end
            end
            ST_BLD_INIT: state_next = ST_CLR_B;
            ST_CLR_B:    state_next = st.idx_end ? ST_SB_HA : ST_CLR_B;
            ST_SB_HA:    state_next = ST_SB_HB;
            ST_SB_HB:    state_next = ST_SB_HC;
            ST_SB_HC:    state_next = st.idx_end ? ST_PRA_B : ST_SB_HA;
            ST_PRA_B:    state_next = ST_PRB_B;
            ST_PRB_B:    state_next = st.idx_end ? ST_SB_LA : ST_PRA_B;
            ST_SB_LA:    state_next = ST_SB_LB;
            ST_SB_LB:    state_next = ST_SB_LC;
            ST_SB_LC:    state_next = st.idx_end ? ST_SB_CA : ST_SB_LA;
            ST_SB_CA:    state_next = ST_SB_CB;
            ST_SB_CB:    state_next = ST_SB_CC;
            ST_SB_CC:
            begin
                if (st.idx_end)
                begin
                    state_next = st.h_lt ? ST_SH_A : ST_RK_A;
                end
                else
                begin
                    state_next = ST_SB_CA;
                end
            end
            ST_SH_A:     state_next = ST_SH_B;
            ST_SH_B:     state_next = st.idx_end ? ST_CLR_D : ST_SH_A;
            ST_CLR_D:    state_next = st.idx_end ? ST_DH_A : ST_CLR_D;
            ST_DH_A:     state_next = ST_DH_B;
            ST_DH_B:     state_next = ST_DH_C;
            ST_DH_C:     state_next = ST_DH_D;
            ST_DH_D:     state_next = st.idx_end ? ST_PRA_D : ST_DH_A;
            ST_PRA_D:    state_next = ST_PRB_D;
            ST_PRB_D:    state_next = st.idx_end ? ST_DP_A : ST_PRA_D;
            ST_DP_A:     state_next = ST_DP_B;
            ST_DP_B:     state_next = ST_DP_C;
            ST_DP_C:     state_next = ST_DP_D;
            ST_DP_D:     state_next = st.idx_end ? ST_RC_A : ST_DP_A;
            ST_RC_A:     state_next = ST_RC_B;
            ST_RC_B:     state_next = ST_RC_C;
            ST_RC_C:     state_next = ST_RC_D;
            ST_RC_D:     state_next = st.idx_end ? ST_CP_A : ST_RC_A;
            ST_CP_A:     state_next = ST_CP_B;
            ST_CP_B:
            begin
                if (st.idx_end)
                begin
                    state_next = st.h2_lt ? ST_SH_A : ST_RK_A;
                end
                else
                begin
                    state_next = ST_CP_A;
                end
            end
            ST_RK_A:     state_next = ST_RK_B;
            ST_RK_B:     state_next = st.idx_end ? ST_KZ : ST_RK_A;
            ST_KZ:       state_next = ST_KA;
            ST_KA:       state_next = ST_KB;
            ST_KB:
            begin
                if (st.r_last)
                begin
                    state_next = st.idx_end ? ST_CNT_M : ST_KA;
                end
                else
                begin
                    state_next = ST_KC;
                end
            end
            ST_KC:       state_next = ST_KD;
            ST_KD:       state_next = st.k_ok ? ST_KE : ST_KW;
            ST_KE:       state_next = ST_KF;
            ST_KF:       state_next = st.chr_eq ? ST_KD : ST_KW;
            ST_KW:       state_next = st.idx_end ? ST_CNT_M : ST_KA;
            ST_CNT_M:    state_next = ST_CNT_S;
            ST_CNT_S:    state_next = ST_IDLE;
            ST_RD:       state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- design/salcp_dp.sv -----
`timescale 1ns / 1ps

module salcp_dp #(
    parameter int MAX_LEN       = salcp_pkg::MAX_LEN_DEF,
    parameter int ALPHABET_SIZE = salcp_pkg::ALPHABET_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  salcp_pkg::item_t  item,
    input  salcp_pkg::cmd_t   cmd,
    output salcp_pkg::stat_t  st,
    output logic              done,
    output salcp_pkg::result_t result
);

    import salcp_pkg::*;

    localparam int SLOTS   = MAX_LEN + 1;
    localparam int BUCKETS = (SLOTS > ALPHABET_SIZE) ? SLOTS : ALPHABET_SIZE;
    localparam int AW      = $clog2(SLOTS);
    localparam int BW      = $clog2(BUCKETS);
    localparam int SW      = $clog2(MAX_LEN + 2);
    localparam int IW      = BW;
    localparam int DW      = (2 * SW + 2 > 22) ? 2 * SW + 2 : 22;

    // Memories
    logic          txt_we, sa_we, cls_we, clsn_we, cnt_we, tmp_we, rnk_we;
    logic [AW-1:0] txt_wa, sa_wa, cls_wa, clsn_wa, tmp_wa, rnk_wa;
    logic [AW-1:0] txt_ra, sa_ra, cls_ra, clsn_ra, tmp_ra, rnk_ra;
    logic [BW-1:0] cnt_wa, cnt_ra;
    logic [7:0]    txt_wd, txt_q;
    logic [SW-1:0] sa_wd, cls_wd, clsn_wd, cnt_wd, tmp_wd, rnk_wd;
    logic [SW-1:0] sa_q, cls_q, clsn_q, cnt_q, tmp_q, rnk_q;

    // Control registers
    logic [SW-1:0] len_reg;
    logic          built_reg;
    logic          ovf_reg;
    logic          done_reg, done_next;
    logic [IW-1:0] i_reg;

    // Working registers
    result_t       res_reg, res_next;
    logic [SW-1:0] size_reg, h_reg, acc_reg, classes_reg;
    logic [7:0]    t_reg, prevb_reg, t1_reg;
    logic [SW-1:0] p_reg, c_reg, a_reg, ca_reg, pca_reg, pca2_reg;
    logic [SW-1:0] k_reg, r_reg, j_reg;
    logic [DW-1:0] lsum_reg;
    logic [2*SW-1:0] prod_reg;

    // Derived values
    logic          is_load, room;
    logic [SW-1:0] eff_len;
    logic [7:0]    code_sat;
    logic [IW:0]   bound;
    logic          adv;
    logic          cls_chg;
    logic [SW-1:0] cnew;
    logic [SW:0]   shift_v, a2_v, ik, jk;
    logic [DW-1:0] diff;
    logic [19:0]   count_v;

    salcp_ram #(.W(8),  .DEPTH(SLOTS)) u_txt (
        .clk(clk), .we(txt_we), .waddr(txt_wa), .wdata(txt_wd),
        .raddr(txt_ra), .rdata(txt_q));
    salcp_ram #(.W(SW), .DEPTH(SLOTS)) u_sa (
        .clk(clk), .we(sa_we), .waddr(sa_wa), .wdata(sa_wd),
        .raddr(sa_ra), .rdata(sa_q));
    salcp_ram #(.W(SW), .DEPTH(SLOTS)) u_cls (
        .clk(clk), .we(cls_we), .waddr(cls_wa), .wdata(cls_wd),
        .raddr(cls_ra), .rdata(cls_q));
    salcp_ram #(.W(SW), .DEPTH(SLOTS)) u_clsn (
        .clk(clk), .we(clsn_we), .waddr(clsn_wa), .wdata(clsn_wd),
        .raddr(clsn_ra), .rdata(clsn_q));
    salcp_ram #(.W(SW), .DEPTH(BUCKETS)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
        .raddr(cnt_ra), .rdata(cnt_q));
    salcp_ram #(.W(SW), .DEPTH(SLOTS)) u_tmp (
        .clk(clk), .we(tmp_we), .waddr(tmp_wa), .wdata(tmp_wd),
        .raddr(tmp_ra), .rdata(tmp_q));
    salcp_ram #(.W(SW), .DEPTH(SLOTS)) u_rnk (
        .clk(clk), .we(rnk_we), .waddr(rnk_wa), .wdata(rnk_wd),
        .raddr(rnk_ra), .rdata(rnk_q));

    // Decode the incoming item
    assign is_load  = cmd.accept && (item.kind == KIND_LOAD);
    assign eff_len  = built_reg ? '0 : len_reg;
    assign room     = (32'(eff_len) < 32'(MAX_LEN));
    assign code_sat = ({1'b0, item.char_code} >= 9'(ALPHABET_SIZE))
                      ? 8'(ALPHABET_SIZE - 1) : item.char_code;

    // Loop bound per pass
    always_comb
    begin
        case (cmd.step)
            ST_CLR_B, ST_PRA_B, ST_PRB_B: bound = (IW+1)'(ALPHABET_SIZE);
            ST_CLR_D, ST_PRA_D, ST_PRB_D: bound = (IW+1)'(classes_reg);
            default:                      bound = (IW+1)'(size_reg);
        endcase
    end

    // Element-done steps advance the loop index
    always_comb
    begin
        case (cmd.step)
            ST_CLR_B, ST_SB_HC, ST_PRB_B, ST_SB_LC, ST_SB_CC, ST_SH_B,
            ST_CLR_D, ST_DH_D, ST_PRB_D, ST_DP_D, ST_RC_D, ST_CP_B,
            ST_RK_B, ST_KW:
                adv = 1'b1;
            ST_KB:
                adv = st.r_last;
            default:
                adv = 1'b0;
        endcase
    end

    // Class numbering and index arithmetic
    assign cls_chg = (cmd.step == ST_SB_CC) ? (txt_q != prevb_reg)
                   : ((ca_reg != pca_reg) || (cls_q != pca2_reg));
    assign cnew    = (i_reg == '0) ? SW'(1) : SW'(classes_reg + SW'(cls_chg));
    assign shift_v = ((SW+1)'(sa_q) + (SW+1)'(size_reg) - (SW+1)'(h_reg)
                      >= (SW+1)'(size_reg))
                   ? (SW+1)'(sa_q) - (SW+1)'(h_reg)
                   : (SW+1)'(sa_q) + (SW+1)'(size_reg) - (SW+1)'(h_reg);
    assign a2_v    = ((SW+1)'(a_reg) + (SW+1)'(h_reg) >= (SW+1)'(size_reg))
                   ? (SW+1)'(a_reg) + (SW+1)'(h_reg) - (SW+1)'(size_reg)
                   : (SW+1)'(a_reg) + (SW+1)'(h_reg);
    assign ik      = (SW+1)'(i_reg) + (SW+1)'(k_reg);
    assign jk      = (SW+1)'(j_reg) + (SW+1)'(k_reg);

    // Status to the controller
    assign st.is_read = (item.kind == KIND_READ);
    assign st.last    = item.last;
    assign st.read_ok = built_reg && (32'(item.rank_index) <= 32'(len_reg));
    assign st.idx_end = (((IW+1)'(i_reg) + (IW+1)'(1)) == bound);
    assign st.r_last  = (rnk_q == SW'(size_reg - SW'(1)));
    assign st.k_ok    = (ik < (SW+1)'(size_reg)) && (jk < (SW+1)'(size_reg));
    assign st.chr_eq  = (txt_q == t1_reg);
    assign st.h_lt    = ((SW+1)'(h_reg) < (SW+1)'(size_reg));
    assign st.h2_lt   = ({h_reg, 1'b0} < (SW+1)'(size_reg));

    // Memory ports per step
    always_comb
    begin
        txt_we = 1'b0;  txt_wa = '0;  txt_wd = '0;  txt_ra = '0;
        sa_we  = 1'b0;  sa_wa  = '0;  sa_wd  = '0;  sa_ra  = '0;
        cls_we = 1'b0;  cls_wa = '0;  cls_wd = '0;  cls_ra = '0;
        clsn_we = 1'b0; clsn_wa = '0; clsn_wd = '0; clsn_ra = '0;
        cnt_we = 1'b0;  cnt_wa = '0;  cnt_wd = '0;  cnt_ra = '0;
        tmp_we = 1'b0;  tmp_wa = '0;  tmp_wd = '0;  tmp_ra = '0;
        rnk_we = 1'b0;  rnk_wa = '0;  rnk_wd = '0;  rnk_ra = '0;
        case (cmd.step)
            ST_IDLE:
            begin
                txt_we = is_load && room;
                txt_wa = AW'(eff_len);
                txt_wd = code_sat;
                sa_ra  = AW'(item.rank_index);
                tmp_ra = AW'(item.rank_index);
            end
            ST_BLD_INIT:
            begin
                txt_we = 1'b1;
                txt_wa = AW'(len_reg);
            end
            ST_CLR_B, ST_CLR_D:
            begin
                cnt_we = 1'b1;
                cnt_wa = BW'(i_reg);
            end
            ST_SB_HA, ST_SB_LA: txt_ra = AW'(i_reg);
            ST_SB_HB, ST_SB_LB: cnt_ra = BW'(txt_q);
            ST_SB_HC:
            begin
                cnt_we = 1'b1;
                cnt_wa = BW'(t_reg);
                cnt_wd = SW'(cnt_q + SW'(1));
            end
            ST_PRA_B, ST_PRA_D: cnt_ra = BW'(i_reg);
            ST_PRB_B, ST_PRB_D:
            begin
                cnt_we = 1'b1;
                cnt_wa = BW'(i_reg);
                cnt_wd = SW'(cnt_q + acc_reg);
            end
            ST_SB_LC:
            begin
                cnt_we = 1'b1;
                cnt_wa = BW'(t_reg);
                cnt_wd = SW'(cnt_q - SW'(1));
                sa_we  = 1'b1;
                sa_wa  = AW'(cnt_q - SW'(1));
                sa_wd  = SW'(i_reg);
            end
            ST_SB_CA: sa_ra  = AW'(i_reg);
            ST_SB_CB: txt_ra = AW'(sa_q);
            ST_SB_CC:
            begin
                cls_we = 1'b1;
                cls_wa = AW'(p_reg);
                cls_wd = SW'(cnew - SW'(1));
            end
            ST_SH_A: sa_ra = AW'(i_reg);
            ST_SH_B:
            begin
                tmp_we = 1'b1;
                tmp_wa = AW'(i_reg);
                tmp_wd = SW'(shift_v);
            end
            ST_DH_A: tmp_ra = AW'(i_reg);
            ST_DH_B, ST_DP_B: cls_ra = AW'(tmp_q);
            ST_DH_C, ST_DP_C: cnt_ra = BW'(cls_q);
            ST_DH_D:
            begin
                cnt_we = 1'b1;
                cnt_wa = BW'(c_reg);
                cnt_wd = SW'(cnt_q + SW'(1));
            end
            ST_DP_A: tmp_ra = AW'(size_reg - SW'(1) - SW'(i_reg));
            ST_DP_D:
            begin
                cnt_we = 1'b1;
                cnt_wa = BW'(c_reg);
                cnt_wd = SW'(cnt_q - SW'(1));
                sa_we  = 1'b1;
                sa_wa  = AW'(cnt_q - SW'(1));
                sa_wd  = p_reg;
            end
            ST_RC_A: sa_ra  = AW'(i_reg);
            ST_RC_B: cls_ra = AW'(sa_q);
            ST_RC_C: cls_ra = AW'(a2_v);
            ST_RC_D:
            begin
                clsn_we = 1'b1;
                clsn_wa = AW'(a_reg);
                clsn_wd = SW'(cnew - SW'(1));
            end
            ST_CP_A: clsn_ra = AW'(i_reg);
            ST_CP_B:
            begin
                cls_we = 1'b1;
                cls_wa = AW'(i_reg);
                cls_wd = clsn_q;
            end
            ST_RK_A: sa_ra = AW'(i_reg);
            ST_RK_B:
            begin
                rnk_we = 1'b1;
                rnk_wa = AW'(sa_q);
                rnk_wd = SW'(i_reg);
            end
            ST_KZ:
            begin
                tmp_we = 1'b1;
                tmp_wa = AW'(size_reg - SW'(1));
            end
            ST_KA: rnk_ra = AW'(i_reg);
            ST_KB: sa_ra  = AW'(rnk_q + SW'(1));
            ST_KD: txt_ra = AW'(ik);
            ST_KE: txt_ra = AW'(jk);
            ST_KW:
            begin
                tmp_we = 1'b1;
                tmp_wa = AW'(r_reg);
                tmp_wd = k_reg;
            end
            default: ;
        endcase
    end

    // Count: half of size*(size-1) less the LCP sum, clamped
    assign diff    = DW'(prod_reg >> 1) - lsum_reg;
    assign count_v = diff[DW-1] ? '0
                   : ((diff > DW'(COUNT_MAX)) ? COUNT_MAX : 20'(diff));

    // Result for this cycle
    always_comb
    begin
        done_next = 1'b0;
        res_next  = '0;
        case (cmd.step)
            ST_IDLE:
            begin
                if (is_load && !room && !item.last)
                begin
                    done_next       = 1'b1;
                    res_next.status = STATUS_OVERFLOW;
                end
                else if (cmd.accept && st.is_read && !st.read_ok)
                begin
                    done_next       = 1'b1;
                    res_next.status = STATUS_BAD_READ;
                end
            end
            ST_RD:
            begin
                done_next             = 1'b1;
                res_next.suffix_start = 11'(sa_q);
                res_next.lcp_next     = (32'(tmp_q) > 32'd1023) ? 10'd1023 : 10'(tmp_q);
            end
            ST_CNT_S:
            begin
                done_next               = 1'b1;
                res_next.distinct_count = count_v;
                res_next.is_count       = 1'b1;
                res_next.status         = ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            built_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (is_load)
            begin
                built_reg <= 1'b0;
                ovf_reg   <= !room;
                len_reg   <= room ? SW'(eff_len + SW'(1)) : eff_len;
            end
            if (cmd.step == ST_CNT_S)
            begin
                built_reg <= 1'b1;
            end
            if (cmd.step == ST_BLD_INIT)
            begin
                i_reg <= '0;
            end
            else if (adv)
            begin
                i_reg <= st.idx_end ? '0 : IW'(i_reg + IW'(1));
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        case (cmd.step)
            ST_BLD_INIT:
            begin
                size_reg <= SW'(len_reg + SW'(1));
                h_reg    <= SW'(1);
                lsum_reg <= '0;
            end
            ST_CLR_B, ST_CLR_D: acc_reg <= '0;
            ST_SB_HB, ST_SB_LB: t_reg <= txt_q;
            ST_PRB_B, ST_PRB_D: acc_reg <= SW'(cnt_q + acc_reg);
            ST_SB_CB: p_reg <= sa_q;
            ST_SB_CC:
            begin
                prevb_reg   <= txt_q;
                classes_reg <= cnew;
            end
            ST_DP_B: p_reg <= tmp_q;
            ST_DH_C, ST_DP_C: c_reg <= cls_q;
            ST_RC_B: a_reg  <= sa_q;
            ST_RC_C: ca_reg <= cls_q;
            ST_RC_D:
            begin
                pca_reg     <= ca_reg;
                pca2_reg    <= cls_q;
                classes_reg <= cnew;
            end
            ST_CP_B:
            begin
                if (st.idx_end)
                begin
                    h_reg <= SW'({h_reg, 1'b0});
                end
            end
            ST_KZ: k_reg <= '0;
            ST_KB:
            begin
                r_reg <= rnk_q;
                if (st.r_last)
                begin
                    k_reg <= '0;
                end
            end
            ST_KC: j_reg  <= sa_q;
            ST_KE: t1_reg <= txt_q;
            ST_KF:
            begin
                if (st.chr_eq)
                begin
                    k_reg <= SW'(k_reg + SW'(1));
                end
            end
            ST_KW:
            begin
                lsum_reg <= lsum_reg + DW'(k_reg);
                k_reg    <= (k_reg != '0) ? SW'(k_reg - SW'(1)) : '0;
            end
            ST_CNT_M: prod_reg <= (2*SW)'(size_reg) * (2*SW)'(SW'(size_reg - SW'(1)));
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- design/suffix_array_lcp_builder_unit.sv -----
`timescale 1ns / 1ps

// Channel  Ports                  Direction  Accepted when
// item     start, busy, item      in         start high and busy low at clk rise
// result   done, result           out        done high, taken at that cycle's end
//
// A plain load leaves the unit idle; a read passes through the read step, and
// its result is registered onto done. The build on the last byte runs the byte
// sort, ceil(log2 n) doubling passes, the rank pass and the LCP pass (n = text
// length + 1). Each memory has a single read port, so every indirect access
// takes a step of its own. Reset clears the length, the built flag and the
// sequencer; memories are not cleared. busy stays high during a build or a
// read; results cannot be held off.

module suffix_array_lcp_builder_unit #(
    parameter int MAX_LEN       = salcp_pkg::MAX_LEN_DEF,
    parameter int ALPHABET_SIZE = salcp_pkg::ALPHABET_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  salcp_pkg::item_t    item,
    output logic                done,
    output salcp_pkg::result_t  result
);

    import salcp_pkg::*;

    cmd_t  cmd;
    stat_t st;

    salcp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    salcp_dp #(
        .MAX_LEN       (MAX_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .st     (st),
        .done   (done),
        .result (result)
    );

endmodule
